// File: rtl/kpu_pkg.sv
// kpu_pkg: shared types, command codes, state encoding and operation program
// for the fixed point kalman filter; no dependencies
package kpu_pkg;

   localparam int DATA_W        = 32;
   localparam int DEF_STATE_DIM = 6;
   localparam int DEF_FRAC_BITS = 16;
   localparam int SLOT_W        = 4;
   localparam int PC_W          = 5;

   localparam logic [3:0] CMD_EST     = 4'd0;
   localparam logic [3:0] CMD_F       = 4'd1;
   localparam logic [3:0] CMD_Q       = 4'd2;
   localparam logic [3:0] CMD_H       = 4'd3;
   localparam logic [3:0] CMD_R       = 4'd4;
   localparam logic [3:0] CMD_P       = 4'd5;
   localparam logic [3:0] CMD_MEAS    = 4'd6;
   localparam logic [3:0] CMD_PREDICT = 4'd7;
   localparam logic [3:0] CMD_UPDATE  = 4'd8;

   localparam logic [PC_W-1:0] PC_PREDICT    = 5'd0;
   localparam logic [PC_W-1:0] PC_UPDATE     = 5'd5;
   localparam logic [PC_W-1:0] PC_UPDATE_OUT = 5'd17;

   typedef struct packed {
      logic [3:0]               cmd;
      logic [2:0]               row;
      logic [2:0]               col;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]               index;
      logic signed [DATA_W-1:0] state_value;
      logic                     singular;
      logic                     last;
   } rsp_type;

   // identity-reset matrices sit in the lowest slots so one sweep sets them
   typedef enum logic [SLOT_W-1:0] {
      SL_P   = 4'd0,
      SL_Q   = 4'd1,
      SL_H   = 4'd2,
      SL_R   = 4'd3,
      SL_F   = 4'd4,
      SL_X   = 4'd5,
      SL_Z   = 4'd6,
      SL_Y   = 4'd7,
      SL_NX  = 4'd8,
      SL_T   = 4'd9,
      SL_S   = 4'd10,
      SL_MB  = 4'd11,
      SL_PHT = 4'd12,
      SL_K   = 4'd13,
      SL_IKH = 4'd14
   } slot_type;

   typedef enum logic [1:0] {
      OP_MM   = 2'd0,
      OP_INV  = 2'd1,
      OP_EMIT = 2'd2
   } opkind_type;

   typedef struct packed {
      opkind_type kind;
      slot_type   dst;
      slot_type   src_a;
      slot_type   src_b;
      slot_type   src_add;
      logic       b_trans;
      logic       vec;
      logic       use_prod;
      logic       use_add;
      logic       neg_add;
      logic       neg_prod;
      logic       ident;
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MM_INIT,
      ST_MM_INITW,
      ST_MM_RD,
      ST_MM_MUL,
      ST_MM_ACC,
      ST_MM_WR,
      ST_PV_RD,
      ST_PV_CMP,
      ST_SW_RD,
      ST_SW_W1,
      ST_SW_W2,
      ST_DV_RD,
      ST_DV_GO,
      ST_DV_WAIT,
      ST_EL_F,
      ST_EL_FW,
      ST_EL_RD,
      ST_EL_MUL,
      ST_EL_WR,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

   function automatic op_type mk_op(
      input opkind_type kind,
      input slot_type   dst,
      input slot_type   src_a,
      input slot_type   src_b,
      input slot_type   src_add,
      input logic       b_trans,
      input logic       vec,
      input logic       use_prod,
      input logic       use_add,
      input logic       neg_add,
      input logic       neg_prod,
      input logic       ident
   );
      op_type o;
      o.kind     = kind;
      o.dst      = dst;
      o.src_a    = src_a;
      o.src_b    = src_b;
      o.src_add  = src_add;
      o.b_trans  = b_trans;
      o.vec      = vec;
      o.use_prod = use_prod;
      o.use_add  = use_add;
      o.neg_add  = neg_add;
      o.neg_prod = neg_prod;
      o.ident    = ident;
      return o;
   endfunction

   // predict and update as sequences of matrix steps
   function automatic op_type prog(input logic [PC_W-1:0] pc);
      op_type o;
      case (pc)
         5'd0: o  = mk_op(OP_MM, SL_NX, SL_F, SL_X, SL_X, 0, 1, 1, 0, 0, 0, 0);
         5'd1: o  = mk_op(OP_MM, SL_X, SL_F, SL_X, SL_NX, 0, 1, 0, 1, 0, 0, 0);
         5'd2: o  = mk_op(OP_MM, SL_T, SL_F, SL_P, SL_P, 0, 0, 1, 0, 0, 0, 0);
         5'd3: o  = mk_op(OP_MM, SL_P, SL_T, SL_F, SL_Q, 1, 0, 1, 1, 0, 0, 0);
         5'd4: o  = mk_op(OP_EMIT, SL_X, SL_X, SL_X, SL_X, 0, 0, 0, 0, 0, 0, 0);
         5'd5: o  = mk_op(OP_MM, SL_Y, SL_H, SL_X, SL_Z, 0, 1, 1, 1, 0, 1, 0);
         5'd6: o  = mk_op(OP_MM, SL_T, SL_H, SL_P, SL_P, 0, 0, 1, 0, 0, 0, 0);
         5'd7: o  = mk_op(OP_MM, SL_S, SL_T, SL_H, SL_R, 1, 0, 1, 1, 0, 0, 0);
         5'd8: o  = mk_op(OP_MM, SL_MB, SL_S, SL_S, SL_S, 0, 0, 0, 0, 0, 0, 1);
         5'd9: o  = mk_op(OP_INV, SL_S, SL_S, SL_S, SL_S, 0, 0, 0, 0, 0, 0, 0);
         5'd10: o = mk_op(OP_MM, SL_PHT, SL_P, SL_H, SL_P, 1, 0, 1, 0, 0, 0, 0);
         5'd11: o = mk_op(OP_MM, SL_K, SL_PHT, SL_MB, SL_P, 0, 0, 1, 0, 0, 0, 0);
         5'd12: o = mk_op(OP_MM, SL_X, SL_K, SL_Y, SL_X, 0, 1, 1, 1, 0, 0, 0);
         5'd13: o = mk_op(OP_MM, SL_PHT, SL_K, SL_H, SL_P, 0, 0, 1, 0, 0, 0, 0);
         5'd14: o = mk_op(OP_MM, SL_IKH, SL_K, SL_H, SL_PHT, 0, 0, 0, 1, 1, 0, 1);
         5'd15: o = mk_op(OP_MM, SL_T, SL_IKH, SL_P, SL_P, 0, 0, 1, 0, 0, 0, 0);
         5'd16: o = mk_op(OP_MM, SL_P, SL_T, SL_T, SL_T, 0, 0, 0, 1, 0, 0, 0);
         default: o = mk_op(OP_EMIT, SL_X, SL_X, SL_X, SL_X, 0, 0, 0, 0, 0, 0, 0);
      endcase
      return o;
   endfunction

endpackage

// File: rtl/kpu_div.sv
// kpu_div: bit-serial signed fixed point divider, (a << frac) / b truncated
// toward zero and saturated to 32 bits; depends on kpu_pkg
module kpu_div #(
   parameter int FRAC_BITS = kpu_pkg::DEF_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [kpu_pkg::DATA_W-1:0]  dividend,
   input  logic signed [kpu_pkg::DATA_W-1:0]  divisor,
   output logic                               done,
   output logic signed [kpu_pkg::DATA_W-1:0]  quotient
);

   localparam int DW    = kpu_pkg::DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DW + 1);
   localparam int W     = kpu_pkg::DATA_W;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [DW-1:0]    num_ff, num_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [W-1:0]     q_ff, q_in;

   logic [W:0]       rem_sh;
   logic             ge;
   logic [W-1:0]     mag_a, mag_b;

   always_comb begin
      mag_a   = dividend[W-1] ? (~dividend + W'(1)) : dividend;
      mag_b   = divisor[W-1] ? (~divisor + W'(1)) : divisor;
      rem_sh  = {rem_ff, num_ff[DW-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      if (start) begin
         num_in = {mag_a, FRAC_BITS'(0)};
         den_in = mag_b;
         rem_in = '0;
         quo_in = '0;
         cnt_in = CNT_W'(DW);
         neg_in = dividend[W-1] ^ divisor[W-1];
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? W'(rem_sh - {1'b0, den_ff}) : rem_sh[W-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         num_in = {num_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               if (quo_in > DW'(32'h8000_0000)) begin
                  q_in = 32'h8000_0000;
               end else begin
                  q_in = ~quo_in[W-1:0] + W'(1);
               end
            end else begin
               if (quo_in > DW'(32'h7fff_ffff)) begin
                  q_in = 32'h7fff_ffff;
               end else begin
                  q_in = quo_in[W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: rtl/kalman_predict_update.sv
// kalman_predict_update: fixed point kalman filter, all matrices in one
// synchronous memory driven by a step sequencer; depends on kpu_pkg, kpu_div
//
// requests enter on req_data when start is high and busy is low. load
// requests (estimate, f, q, h, r, p, measurement elements) are stored and
// leave busy low; an index at or above the dimension is dropped. predict and
// update requests raise busy until the estimate has been sent: one result per
// element on rsp_data, each marked by rsp_valid for a single cycle, last set
// on the final element. the receiver cannot stall; results are never held.
// every product term passes through read, multiply and accumulate states
// on the one shared 32x32 multiplier, and each gauss-jordan division runs
// on the bit-serial divider. an update with a zero pivot stops early and
// flags singular.
// after reset the block sweeps 4 * 4^ceil(log2(n)) memory words (256 at six
// states) to set p, q, h and r to identity, with busy high throughout.
module kalman_predict_update #(
   parameter int STATE_DIM = kpu_pkg::DEF_STATE_DIM,
   parameter int FRAC_BITS = kpu_pkg::DEF_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kpu_pkg::req_type req_data,
   output logic             rsp_valid,
   output kpu_pkg::rsp_type rsp_data
);

   localparam int W      = kpu_pkg::DATA_W;
   localparam int IDX_W  = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
   localparam int ADDR_W = kpu_pkg::SLOT_W + 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int CLR_W  = 2 + 2 * IDX_W;
   localparam int ACC_W  = 68 - FRAC_BITS;
   localparam int PC_W   = kpu_pkg::PC_W;

   localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(STATE_DIM - 1);
   localparam logic [CLR_W-1:0]        CLR_LAST = '1;
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ONE_ACC  = ACC_W'(1) << FRAC_BITS;
   localparam logic signed [W-1:0]     ONE_W    = W'(1) << FRAC_BITS;
   localparam logic signed [63:0]      HALF     = 64'sd1 <<< (FRAC_BITS - 1);

   function automatic logic [ADDR_W-1:0] addr(
      input kpu_pkg::slot_type s,
      input logic [IDX_W-1:0]  r,
      input logic [IDX_W-1:0]  c
   );
      return {s, r, c};
   endfunction

   function automatic logic [ADDR_W-1:0] maddr(
      input logic [IDX_W-1:0] r,
      input logic             h,
      input logic [IDX_W-1:0] c
   );
      return addr(h ? kpu_pkg::SL_MB : kpu_pkg::SL_S, r, c);
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [ACC_W-1:0] v);
      logic signed [W-1:0] o;
      if (v > SAT_MAX) begin
         o = SAT_MAX[W-1:0];
      end else if (v < SAT_MIN) begin
         o = SAT_MIN[W-1:0];
      end else begin
         o = v[W-1:0];
      end
      return o;
   endfunction

   logic signed [W-1:0] mem [DEPTH];
   logic signed [W-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr, wr_addr;
   logic                wr_en;
   logic signed [W-1:0] wr_data;

   kpu_pkg::state_type state_ff, state_in;
   kpu_pkg::op_type    op_ff, op_in, fop;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0]   c_ff, c_in, r_ff, r_in, p_ff, p_in;
   logic               h_ff, h_in;
   logic               sing_ff, sing_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [W-1:0]     tmp_ff, tmp_in, f_ff, f_in, piv_ff, piv_in;
   logic [W-1:0]            best_ff, best_in;

   logic               accept, is_load, idx_ok, row_ok;
   logic               j_last, i_last, k_last, r_last, c_last, hj_last;
   logic               mm_jlast, mm_done;
   logic [W-1:0]       mag;
   logic               take;
   logic [W-1:0]       best_new;
   logic [IDX_W-1:0]   p_new;
   logic signed [63:0] rnd64;
   logic signed [ACC_W-1:0] rnd, init_v, add_v;
   logic signed [W-1:0] mul_a;
   logic               div_start, div_done;
   logic signed [W-1:0] div_q;
   kpu_pkg::slot_type  ld_slot;

   kpu_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_a_ff),
      .divisor  (piv_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign accept   = start && (state_ff == kpu_pkg::ST_IDLE);
   assign fop      = kpu_pkg::prog(pc_ff);
   assign j_last   = (j_ff == LAST_IDX);
   assign i_last   = (i_ff == LAST_IDX);
   assign k_last   = (k_ff == LAST_IDX);
   assign r_last   = (r_ff == LAST_IDX);
   assign c_last   = (c_ff == LAST_IDX);
   assign hj_last  = h_ff && j_last;
   assign mm_jlast = op_ff.vec || j_last;
   assign mm_done  = i_last && mm_jlast;
   assign mag      = rd_a_ff[W-1] ? (~rd_a_ff + W'(1)) : rd_a_ff;
   assign take     = (r_ff == c_ff) || (mag > best_ff);
   assign best_new = take ? mag : best_ff;
   assign p_new    = take ? r_ff : p_ff;
   assign rnd64    = (prod_ff + HALF) >>> FRAC_BITS;
   assign rnd      = ACC_W'(rnd64);
   assign row_ok   = ({29'd0, req_data.row} < 32'(STATE_DIM));
   assign mul_a    = (state_ff == kpu_pkg::ST_EL_MUL) ? f_ff : rd_a_ff;
   assign prod_in  = mul_a * rd_b_ff;

   always_comb begin
      ld_slot = kpu_pkg::SL_X;
      is_load = 1'b1;
      idx_ok  = row_ok && ({29'd0, req_data.col} < 32'(STATE_DIM));
      case (req_data.cmd)
         kpu_pkg::CMD_EST: begin
            ld_slot = kpu_pkg::SL_X;
            idx_ok  = row_ok;
         end
         kpu_pkg::CMD_F:    ld_slot = kpu_pkg::SL_F;
         kpu_pkg::CMD_Q:    ld_slot = kpu_pkg::SL_Q;
         kpu_pkg::CMD_H:    ld_slot = kpu_pkg::SL_H;
         kpu_pkg::CMD_R:    ld_slot = kpu_pkg::SL_R;
         kpu_pkg::CMD_P:    ld_slot = kpu_pkg::SL_P;
         kpu_pkg::CMD_MEAS: begin
            ld_slot = kpu_pkg::SL_Z;
            idx_ok  = row_ok;
         end
         default: is_load = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kpu_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = kpu_pkg::ST_IDLE;
         end
         kpu_pkg::ST_IDLE: begin
            if (accept && (req_data.cmd == kpu_pkg::CMD_PREDICT ||
                           req_data.cmd == kpu_pkg::CMD_UPDATE)) begin
               state_in = kpu_pkg::ST_FETCH;
            end
         end
         kpu_pkg::ST_FETCH: begin
            case (fop.kind)
               kpu_pkg::OP_MM:  state_in = kpu_pkg::ST_MM_INIT;
               kpu_pkg::OP_INV: state_in = kpu_pkg::ST_PV_RD;
               default:         state_in = kpu_pkg::ST_EM_RD;
            endcase
         end
         kpu_pkg::ST_MM_INIT:  state_in = kpu_pkg::ST_MM_INITW;
         kpu_pkg::ST_MM_INITW: begin
            state_in = op_ff.use_prod ? kpu_pkg::ST_MM_RD : kpu_pkg::ST_MM_WR;
         end
         kpu_pkg::ST_MM_RD:  state_in = kpu_pkg::ST_MM_MUL;
         kpu_pkg::ST_MM_MUL: state_in = kpu_pkg::ST_MM_ACC;
         kpu_pkg::ST_MM_ACC: begin
            state_in = k_last ? kpu_pkg::ST_MM_WR : kpu_pkg::ST_MM_RD;
         end
         kpu_pkg::ST_MM_WR: begin
            state_in = mm_done ? kpu_pkg::ST_FETCH : kpu_pkg::ST_MM_INIT;
         end
         kpu_pkg::ST_PV_RD: state_in = kpu_pkg::ST_PV_CMP;
         kpu_pkg::ST_PV_CMP: begin
            if (r_last) begin
               if (best_new == '0) begin
                  state_in = kpu_pkg::ST_FETCH;
               end else if (p_new != c_ff) begin
                  state_in = kpu_pkg::ST_SW_RD;
               end else begin
                  state_in = kpu_pkg::ST_DV_RD;
               end
            end else begin
               state_in = kpu_pkg::ST_PV_RD;
            end
         end
         kpu_pkg::ST_SW_RD: state_in = kpu_pkg::ST_SW_W1;
         kpu_pkg::ST_SW_W1: state_in = kpu_pkg::ST_SW_W2;
         kpu_pkg::ST_SW_W2: begin
            state_in = hj_last ? kpu_pkg::ST_DV_RD : kpu_pkg::ST_SW_RD;
         end
         kpu_pkg::ST_DV_RD: state_in = kpu_pkg::ST_DV_GO;
         kpu_pkg::ST_DV_GO: state_in = kpu_pkg::ST_DV_WAIT;
         kpu_pkg::ST_DV_WAIT: begin
            if (div_done) state_in = hj_last ? kpu_pkg::ST_EL_F : kpu_pkg::ST_DV_RD;
         end
         kpu_pkg::ST_EL_F: begin
            if (r_ff == c_ff) begin
               if (r_last) begin
                  state_in = c_last ? kpu_pkg::ST_FETCH : kpu_pkg::ST_PV_RD;
               end
            end else begin
               state_in = kpu_pkg::ST_EL_FW;
            end
         end
         kpu_pkg::ST_EL_FW:  state_in = kpu_pkg::ST_EL_RD;
         kpu_pkg::ST_EL_RD:  state_in = kpu_pkg::ST_EL_MUL;
         kpu_pkg::ST_EL_MUL: state_in = kpu_pkg::ST_EL_WR;
         kpu_pkg::ST_EL_WR: begin
            if (hj_last) begin
               if (r_last) begin
                  state_in = c_last ? kpu_pkg::ST_FETCH : kpu_pkg::ST_PV_RD;
               end else begin
                  state_in = kpu_pkg::ST_EL_F;
               end
            end else begin
               state_in = kpu_pkg::ST_EL_RD;
            end
         end
         kpu_pkg::ST_EM_RD:  state_in = kpu_pkg::ST_EM_OUT;
         kpu_pkg::ST_EM_OUT: begin
            if (i_last) state_in = kpu_pkg::ST_IDLE;
         end
         default: state_in = kpu_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in     = op_ff;
      pc_in     = pc_ff;
      clr_in    = clr_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      c_in      = c_ff;
      r_in      = r_ff;
      p_in      = p_ff;
      h_in      = h_ff;
      sing_in   = sing_ff;
      acc_in    = acc_ff;
      tmp_in    = tmp_ff;
      f_in      = f_ff;
      piv_in    = piv_ff;
      best_in   = best_ff;
      rd_a_addr = '0;
      rd_b_addr = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      div_start = 1'b0;
      rsp_valid = 1'b0;
      rsp_data  = '0;
      add_v     = '0;
      init_v    = '0;
      case (state_ff)
         kpu_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(clr_ff);
            wr_data = (clr_ff[2*IDX_W-1:IDX_W] == clr_ff[IDX_W-1:0]) ? ONE_W : '0;
            clr_in  = clr_ff + CLR_W'(1);
         end
         kpu_pkg::ST_IDLE: begin
            if (accept) begin
               sing_in = 1'b0;
               pc_in   = (req_data.cmd == kpu_pkg::CMD_PREDICT) ?
                         kpu_pkg::PC_PREDICT : kpu_pkg::PC_UPDATE;
               if (is_load && idx_ok) begin
                  wr_en   = 1'b1;
                  wr_data = req_data.value;
                  if (ld_slot == kpu_pkg::SL_X || ld_slot == kpu_pkg::SL_Z) begin
                     wr_addr = addr(ld_slot, req_data.row[IDX_W-1:0], '0);
                  end else begin
                     wr_addr = addr(ld_slot, req_data.row[IDX_W-1:0],
                                    req_data.col[IDX_W-1:0]);
                  end
               end
            end
         end
         kpu_pkg::ST_FETCH: begin
            op_in = fop;
            i_in  = '0;
            j_in  = '0;
            k_in  = '0;
            c_in  = '0;
            r_in  = '0;
            h_in  = 1'b0;
         end
         kpu_pkg::ST_MM_INIT: begin
            rd_a_addr = addr(op_ff.src_add, i_ff, j_ff);
         end
         kpu_pkg::ST_MM_INITW: begin
            if (op_ff.use_add) begin
               add_v = op_ff.neg_add ? -ACC_W'(rd_a_ff) : ACC_W'(rd_a_ff);
            end
            init_v = (op_ff.ident && i_ff == j_ff) ? ONE_ACC : '0;
            acc_in = init_v + add_v;
            k_in   = '0;
         end
         kpu_pkg::ST_MM_RD: begin
            rd_a_addr = addr(op_ff.src_a, i_ff, k_ff);
            rd_b_addr = op_ff.b_trans ? addr(op_ff.src_b, j_ff, k_ff) :
                                        addr(op_ff.src_b, k_ff, j_ff);
         end
         kpu_pkg::ST_MM_ACC: begin
            acc_in = op_ff.neg_prod ? (acc_ff - rnd) : (acc_ff + rnd);
            k_in   = k_ff + IDX_W'(1);
         end
         kpu_pkg::ST_MM_WR: begin
            wr_en   = 1'b1;
            wr_addr = addr(op_ff.dst, i_ff, j_ff);
            wr_data = sat(acc_ff);
            if (mm_jlast) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
            if (mm_done) pc_in = pc_ff + PC_W'(1);
         end
         kpu_pkg::ST_PV_RD: begin
            rd_a_addr = maddr(r_ff, 1'b0, c_ff);
         end
         kpu_pkg::ST_PV_CMP: begin
            if (take) begin
               best_in = mag;
               p_in    = r_ff;
               piv_in  = rd_a_ff;
            end
            if (r_last) begin
               h_in = 1'b0;
               j_in = '0;
               if (best_new == '0) begin
                  sing_in = 1'b1;
                  pc_in   = kpu_pkg::PC_UPDATE_OUT;
               end
            end else begin
               r_in = r_ff + IDX_W'(1);
            end
         end
         kpu_pkg::ST_SW_RD: begin
            rd_a_addr = maddr(c_ff, h_ff, j_ff);
            rd_b_addr = maddr(p_ff, h_ff, j_ff);
         end
         kpu_pkg::ST_SW_W1: begin
            wr_en   = 1'b1;
            wr_addr = maddr(c_ff, h_ff, j_ff);
            wr_data = rd_b_ff;
            tmp_in  = rd_a_ff;
         end
         kpu_pkg::ST_SW_W2: begin
            wr_en   = 1'b1;
            wr_addr = maddr(p_ff, h_ff, j_ff);
            wr_data = tmp_ff;
            j_in    = j_last ? '0 : j_ff + IDX_W'(1);
            if (j_last) h_in = ~h_ff;
         end
         kpu_pkg::ST_DV_RD: begin
            rd_a_addr = maddr(c_ff, h_ff, j_ff);
         end
         kpu_pkg::ST_DV_GO: begin
            div_start = 1'b1;
         end
         kpu_pkg::ST_DV_WAIT: begin
            if (div_done) begin
               wr_en   = 1'b1;
               wr_addr = maddr(c_ff, h_ff, j_ff);
               wr_data = div_q;
               j_in    = j_last ? '0 : j_ff + IDX_W'(1);
               if (j_last) h_in = ~h_ff;
               if (hj_last) r_in = '0;
            end
         end
         kpu_pkg::ST_EL_F: begin
            if (r_ff == c_ff) begin
               if (r_last) begin
                  if (c_last) begin
                     pc_in = pc_ff + PC_W'(1);
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                     r_in = c_ff + IDX_W'(1);
                  end
               end else begin
                  r_in = r_ff + IDX_W'(1);
               end
            end else begin
               rd_a_addr = maddr(r_ff, 1'b0, c_ff);
            end
         end
         kpu_pkg::ST_EL_FW: begin
            f_in = rd_a_ff;
            h_in = 1'b0;
            j_in = '0;
         end
         kpu_pkg::ST_EL_RD: begin
            rd_a_addr = maddr(r_ff, h_ff, j_ff);
            rd_b_addr = maddr(c_ff, h_ff, j_ff);
         end
         kpu_pkg::ST_EL_MUL: begin
            tmp_in = rd_a_ff;
         end
         kpu_pkg::ST_EL_WR: begin
            wr_en   = 1'b1;
            wr_addr = maddr(r_ff, h_ff, j_ff);
            wr_data = sat(ACC_W'(tmp_ff) - rnd);
            j_in    = j_last ? '0 : j_ff + IDX_W'(1);
            if (j_last) h_in = ~h_ff;
            if (hj_last) begin
               if (r_last) begin
                  if (c_last) begin
                     pc_in = pc_ff + PC_W'(1);
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                     r_in = c_ff + IDX_W'(1);
                  end
               end else begin
                  r_in = r_ff + IDX_W'(1);
               end
            end
         end
         kpu_pkg::ST_EM_RD: begin
            rd_a_addr = addr(kpu_pkg::SL_X, i_ff, '0);
         end
         kpu_pkg::ST_EM_OUT: begin
            rsp_valid            = 1'b1;
            rsp_data.index       = 3'(i_ff);
            rsp_data.state_value = rd_a_ff;
            rsp_data.singular    = sing_ff;
            rsp_data.last        = i_last;
            rd_a_addr            = addr(kpu_pkg::SL_X, i_ff + IDX_W'(1), '0);
            i_in                 = i_ff + IDX_W'(1);
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kpu_pkg::ST_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= '0;
         sing_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         sing_ff  <= sing_in;
      end
      op_ff   <= op_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      c_ff    <= c_in;
      r_ff    <= r_in;
      p_ff    <= p_in;
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      f_ff    <= f_in;
      piv_ff  <= piv_in;
      best_ff <= best_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign busy = (state_ff != kpu_pkg::ST_IDLE);

endmodule
